FILE: rtl/telescope_set_command_parser_macros.svh
// Assertion macros used by the set command parser record queue.
`ifndef TELESCOPE_SET_COMMAND_PARSER_MACROS_SVH
`define TELESCOPE_SET_COMMAND_PARSER_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define TSCP_CHECK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define TSCP_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

FILE: rtl/tscp_pkg.sv
// Types, constants and grammar tables of the set command parser.
`default_nettype none
package tscp_pkg;

	typedef enum logic [3:0] {
		K_DEC, K_RA, K_SID, K_HOME, K_HA, K_SYNC, K_LAT, K_LONG, K_UTC, K_TIME, K_DATE, K_NONE
	} kind_t;

	typedef enum logic [2:0] {C_SIGN, C_DIGIT, C_SEP, C_ANY, C_LIT} cls_t;

	typedef struct packed {
		cls_t       cls;
		logic [7:0] lit;
		logic [2:0] slot;
	} cell_t;

	localparam int NSLOT = 6;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_L     = 8'h4C;
	localparam logic [7:0] CH_P     = 8'h50;
	localparam logic [11:0] YEAR_BASE = 12'd2000;

	// One finished command body as seen by the back end.
	typedef struct packed {
		kind_t       kind;
		logic        failed;
		logic        sign;
		logic [4:0]  pos;
		logic [1:0]  off;
		logic [NSLOT-1:0][9:0] fld;
	} rec_t;

	// One result record.
	typedef struct packed {
		kind_t             kind;
		logic              ok;
		logic              neg;
		logic [7:0]        v1;
		logic [6:0]        v2;
		logic [6:0]        v3;
		logic [6:0]        rah;
		logic [6:0]        ram;
		logic [6:0]        ras;
		logic signed [7:0] utc;
		logic [11:0]       yr;
	} res_t;

	function automatic kind_t kind_of(input logic [7:0] ch);
		unique case (ch)
			8'h64: return K_DEC;
			8'h72: return K_RA;
			8'h48: return K_HA;
			8'h59: return K_SYNC;
			8'h74: return K_LAT;
			8'h67: return K_LONG;
			8'h47: return K_UTC;
			8'h4C: return K_TIME;
			8'h43: return K_DATE;
			default: return K_NONE;
		endcase
	endfunction

	function automatic logic [4:0] gram_len(input kind_t k);
		unique case (k)
			K_DEC: return 5'd9;
			K_RA, K_TIME, K_DATE: return 5'd8;
			K_SID, K_LAT, K_LONG: return 5'd6;
			K_HA: return 5'd5;
			K_SYNC: return 5'd18;
			K_UTC: return 5'd3;
			default: return 5'd0;
		endcase
	endfunction

	function automatic logic gram_exact(input kind_t k);
		return (k == K_SID) || (k == K_HOME) || (k == K_HA);
	endfunction

	function automatic cell_t mk(input cls_t c, input logic [7:0] l, input logic [2:0] s);
		cell_t r;
		r.cls = c;
		r.lit = l;
		r.slot = s;
		return r;
	endfunction

	// Pattern cell of grammar k at position q (q below its length).
	function automatic cell_t gram_cell(input kind_t k, input logic [4:0] q);
		cell_t r;
		r = mk(C_ANY, 8'h00, 3'd0);
		unique case (k)
			K_DEC, K_SYNC, K_LAT: begin
				unique case (q)
					5'd0: r = mk(C_SIGN, 8'h00, 3'd0);
					5'd1, 5'd2: r = mk(C_DIGIT, 8'h00, 3'd0);
					5'd3: r = mk(C_SEP, 8'h00, 3'd0);
					5'd4, 5'd5: r = mk(C_DIGIT, 8'h00, 3'd1);
					5'd6, 5'd12, 5'd15: r = mk(C_LIT, CH_COLON, 3'd0);
					5'd7, 5'd8: r = mk(C_DIGIT, 8'h00, 3'd2);
					5'd9: r = mk(C_LIT, CH_DOT, 3'd0);
					5'd10, 5'd11: r = mk(C_DIGIT, 8'h00, 3'd3);
					5'd13, 5'd14: r = mk(C_DIGIT, 8'h00, 3'd4);
					5'd16, 5'd17: r = mk(C_DIGIT, 8'h00, 3'd5);
					default: r = mk(C_ANY, 8'h00, 3'd0);
				endcase
			end
			K_RA, K_TIME, K_DATE: begin
				unique case (q)
					5'd0, 5'd1: r = mk(C_DIGIT, 8'h00, 3'd0);
					5'd2, 5'd5: r = mk(C_LIT, (k == K_DATE) ? CH_SLASH : CH_COLON, 3'd0);
					5'd3, 5'd4: r = mk(C_DIGIT, 8'h00, 3'd1);
					5'd6, 5'd7: r = mk(C_DIGIT, 8'h00, 3'd2);
					default: r = mk(C_ANY, 8'h00, 3'd0);
				endcase
			end
			K_SID: r = mk(C_DIGIT, 8'h00, 3'(q >> 1));
			K_HA: begin
				unique case (q)
					5'd0, 5'd1: r = mk(C_DIGIT, 8'h00, 3'd0);
					5'd3, 5'd4: r = mk(C_DIGIT, 8'h00, 3'd1);
					default: r = mk(C_ANY, 8'h00, 3'd0);
				endcase
			end
			K_LONG: begin
				unique case (q)
					5'd0, 5'd1, 5'd2: r = mk(C_DIGIT, 8'h00, 3'd0);
					5'd3: r = mk(C_SEP, 8'h00, 3'd0);
					5'd4, 5'd5: r = mk(C_DIGIT, 8'h00, 3'd1);
					default: r = mk(C_ANY, 8'h00, 3'd0);
				endcase
			end
			K_UTC: begin
				unique case (q)
					5'd0: r = mk(C_SIGN, 8'h00, 3'd0);
					default: r = mk(C_DIGIT, 8'h00, 3'd0);
				endcase
			end
			default: r = mk(C_ANY, 8'h00, 3'd0);
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/tscp_front.sv
// Front end: takes body bytes, tracks the grammar and emits one record per command.
`default_nettype none
module tscp_front import tscp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       take,
	input  wire logic [7:0] char_code,
	output rec_t            rec,
	output logic            rec_push
);
	logic [4:0] pos_q, pos_n;
	kind_t kind_q, kind_n;
	logic sign_q, sign_n, failed_q, failed_n;
	logic [1:0] off_q, off_n;
	logic [NSLOT-1:0][9:0] fld_q, fld_n;

	// Parse one byte.
	always_comb begin
		logic done;
		kind_t k;
		logic [4:0] q;
		cell_t c;
		logic is_sign, is_digit;
		logic [13:0] acc;
		pos_n = pos_q;
		kind_n = kind_q;
		sign_n = sign_q;
		failed_n = failed_q;
		off_n = off_q;
		fld_n = fld_q;
		done = 1'b0;
		k = kind_q;
		q = '0;
		c = mk(C_ANY, 8'h00, 3'd0);
		acc = '0;
		is_sign = (char_code == CH_PLUS) || (char_code == CH_MINUS);
		is_digit = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
		rec.kind = kind_q;
		rec.failed = failed_q;
		rec.sign = sign_q;
		rec.pos = pos_q;
		rec.off = off_q;
		rec.fld = fld_q;
		rec_push = take && (char_code == 8'h00);
		if (take) begin
			if (char_code == 8'h00) begin
				// Drop the command state once the record leaves.
				pos_n = '0;
				kind_n = K_NONE;
				sign_n = 1'b0;
				failed_n = 1'b0;
				off_n = '0;
				fld_n = '0;
			end else begin
				if (pos_q != 5'd31) pos_n = pos_q + 5'd1;
				if (pos_q == 5'd0) begin
					kind_n = kind_of(char_code);
					off_n = 2'd1;
				end else if (!failed_q && kind_q != K_NONE) begin
					// Split the H forms on their second byte.
					if (k == K_HA && off_q == 2'd1 && pos_q == 5'd1) begin
						if (char_code == CH_L) begin
							kind_n = K_SID;
							off_n = 2'd2;
							done = 1'b1;
						end else if (char_code == CH_P) begin
							kind_n = K_HOME;
							off_n = 2'd2;
							done = 1'b1;
						end
					end
					if (!done && k == K_HOME) begin
						k = K_HA;
						kind_n = K_HA;
						off_n = 2'd2;
					end
					// Take the optional longitude sign.
					if (!done && k == K_LONG && off_q == 2'd1 && pos_q == 5'd1 && is_sign) begin
						sign_n = (char_code == CH_MINUS);
						off_n = 2'd2;
						done = 1'b1;
					end
					if (!done && pos_q >= {3'b000, off_n}) begin
						q = pos_q - {3'b000, off_n};
						if (q >= gram_len(k)) begin
							if (gram_exact(k)) failed_n = 1'b1;
						end else begin
							c = gram_cell(k, q);
							unique case (c.cls)
								C_SIGN: begin
									if (is_sign) sign_n = (char_code == CH_MINUS);
									else failed_n = 1'b1;
								end
								C_DIGIT: begin
									if (is_digit) begin
										acc = 14'(fld_q[c.slot]) * 14'd10
											+ 14'(char_code - CH_ZERO);
										fld_n[c.slot] = acc[9:0];
									end else begin
										failed_n = 1'b1;
									end
								end
								C_SEP: begin
									if (char_code != CH_STAR && char_code != CH_COLON)
										failed_n = 1'b1;
								end
								C_ANY: begin
								end
								C_LIT: begin
									if (char_code != c.lit) failed_n = 1'b1;
								end
								default: failed_n = 1'b1;
							endcase
						end
					end
				end
			end
		end
	end

	// Hold the parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			kind_q <= K_NONE;
			sign_q <= 1'b0;
			failed_q <= 1'b0;
			off_q <= '0;
			fld_q <= '0;
		end else begin
			pos_q <= pos_n;
			kind_q <= kind_n;
			sign_q <= sign_n;
			failed_q <= failed_n;
			off_q <= off_n;
			fld_q <= fld_n;
		end
	end
endmodule
`default_nettype wire

FILE: rtl/tscp_queue.sv
// Two-entry record queue between front and back end.
`default_nettype none
`include "telescope_set_command_parser_macros.svh"
module tscp_queue import tscp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire rec_t din,
	output logic      qfull,
	output logic      qvalid,
	input  wire logic pop,
	output rec_t      dout
);
	rec_t entry_q [2];
	logic wr_q, rd_q;
	logic [1:0] count_q;

	assign qfull = (count_q == 2'd2);
	assign qvalid = (count_q != 2'd0);
	assign dout = entry_q[rd_q];

	// Store records.
	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= din;
	end

	// Advance pointers and count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	`TSCP_NEVER(a_cnt_range, clk, arst_n, count_q == 2'd3, "queue count out of range")
	`TSCP_NEVER(a_pop_empty, clk, arst_n, pop && count_q == 2'd0, "pop from empty queue")
	`TSCP_CHECK(a_cnt_up, clk, arst_n,
		(push && !pop) |=> (count_q == $past(count_q) + 2'd1), "queue count lost a push")
endmodule
`default_nettype wire

FILE: rtl/tscp_back.sv
// Back end: checks each record, maps the fields and holds the result.
`default_nettype none
module tscp_back import tscp_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic qvalid,
	input  wire rec_t rec,
	output logic      qpop,
	input  wire logic pop,
	output logic      empty,
	output res_t      res
);
	res_t r;
	logic valid_q;

	assign qpop = qvalid && (!valid_q || pop);
	assign empty = !valid_q;

	// Work out the result of one record.
	always_comb begin
		logic [4:0] q;
		logic ok;
		logic [9:0] ddd, mm;
		logic near;
		q = rec.pos - {3'b000, rec.off};
		ddd = rec.fld[0];
		mm = rec.fld[1];
		ok = 1'b0;
		near = 1'b0;
		r = '0;
		r.kind = rec.kind;
		if (rec.kind != K_NONE && !rec.failed && rec.pos >= {3'b000, rec.off}) begin
			if (rec.kind == K_SID) ok = (q == 5'd4) || (q == 5'd6);
			else if (gram_exact(rec.kind)) ok = (q == gram_len(rec.kind));
			else ok = (q >= gram_len(rec.kind));
		end
		if (ok && rec.kind == K_LONG && (ddd >= 10'd360 || mm >= 10'd60)) ok = 1'b0;
		if (ok) begin
			unique case (rec.kind)
				K_DEC, K_SYNC, K_LAT: begin
					r.neg = rec.sign;
					r.v1 = rec.fld[0][7:0];
					r.v2 = rec.fld[1][6:0];
					if (rec.kind != K_LAT) r.v3 = rec.fld[2][6:0];
					if (rec.kind == K_SYNC) begin
						r.rah = rec.fld[3][6:0];
						r.ram = rec.fld[4][6:0];
						r.ras = rec.fld[5][6:0];
					end
				end
				K_RA, K_SID, K_TIME: begin
					r.v1 = rec.fld[0][7:0];
					r.v2 = rec.fld[1][6:0];
					r.v3 = rec.fld[2][6:0];
				end
				K_HA: begin
					r.v1 = rec.fld[0][7:0];
					r.v2 = rec.fld[1][6:0];
				end
				K_LONG: begin
					// Wrap to east-positive; near means the magnitude is the value itself.
					if (rec.sign) near = (ddd < 10'd180) || (ddd == 10'd180 && mm == 10'd0);
					else near = (ddd < 10'd180);
					if (near) begin
						r.neg = 1'b0;
						if (!rec.sign) r.neg = (ddd != 10'd0) || (mm != 10'd0);
						r.v1 = ddd[7:0];
						r.v2 = mm[6:0];
					end else begin
						r.neg = rec.sign;
						if (mm == 10'd0) begin
							r.v1 = 8'(10'd360 - ddd);
							r.v2 = '0;
						end else begin
							r.v1 = 8'(10'd359 - ddd);
							r.v2 = 7'(10'd60 - mm);
						end
					end
				end
				K_UTC: r.utc = rec.sign ? 8'(8'd0 - rec.fld[0][7:0]) : rec.fld[0][7:0];
				K_DATE: begin
					r.v1 = rec.fld[0][7:0];
					r.v2 = rec.fld[1][6:0];
					r.yr = YEAR_BASE + 12'(rec.fld[2]);
				end
				default: begin
				end
			endcase
		end
		r.ok = ok;
	end

	// Hold the result until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) valid_q <= 1'b0;
		else if (qpop) valid_q <= 1'b1;
		else if (pop) valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (qpop) res <= r;
	end
endmodule
`default_nettype wire

FILE: rtl/telescope_set_command_parser.sv
// Top level of the telescope set command parser.
// Input channel: push a body byte on char_code with push while full is low.
// A zero byte ends the command and produces exactly one result record;
// every other byte produces none.
// Result channel: while empty is low the oldest record sits on the result
// ports; pop takes it.
// Throughput: one byte per cycle while full is low, set by the parse step of the
// front end.
// Path: a record reaches the result ports through the record queue, then the
// result register, and waits in the queue while an untaken result is held.
// The two-entry record queue lets the front end keep taking bytes while the
// result register waits for pop; full rises only when the queue holds two
// records, and bytes are then held off.
// Reset (arst_n low) clears the parse state, the queue and the result valid
// flag; no record is pending afterward.
`default_nettype none
module telescope_set_command_parser import tscp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       push,
	output logic            full,
	input  wire logic [7:0] char_code,
	output logic            empty,
	input  wire logic       pop,
	output logic [3:0]      command_kind,
	output logic            accepted,
	output logic            negative,
	output logic [7:0]      first_value,
	output logic [6:0]      second_value,
	output logic [6:0]      third_value,
	output logic [6:0]      ra_hours,
	output logic [6:0]      ra_minutes,
	output logic [6:0]      ra_seconds,
	output logic signed [7:0] utc_offset,
	output logic [11:0]     year
);
	rec_t rec_in, rec_out;
	res_t res;
	logic rec_push, qfull, qvalid, qpop;

	assign full = qfull;

	tscp_front u_front (
		.clk(clk), .arst_n(arst_n), .take(push && !qfull), .char_code(char_code),
		.rec(rec_in), .rec_push(rec_push)
	);

	tscp_queue u_queue (
		.clk(clk), .arst_n(arst_n), .push(rec_push), .din(rec_in), .qfull(qfull),
		.qvalid(qvalid), .pop(qpop), .dout(rec_out)
	);

	tscp_back u_back (
		.clk(clk), .arst_n(arst_n), .qvalid(qvalid), .rec(rec_out), .qpop(qpop),
		.pop(pop), .empty(empty), .res(res)
	);

	// Drive the result ports.
	assign command_kind = res.kind;
	assign accepted = res.ok;
	assign negative = res.neg;
	assign first_value = res.v1;
	assign second_value = res.v2;
	assign third_value = res.v3;
	assign ra_hours = res.rah;
	assign ra_minutes = res.ram;
	assign ra_seconds = res.ras;
	assign utc_offset = res.utc;
	assign year = res.yr;
endmodule
`default_nettype wire
